>>> rtl/orrt_pkg.sv
`default_nettype none
package orrt_pkg;
  localparam int Depth = 16;
  localparam int TimeW = 16;
  localparam int CntW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RESP = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_XMIT = 3'd0,
    K_MATCH = 3'd1,
    K_UNASSIGN = 3'd2,
    K_RESEND = 3'd3,
    K_EXPIRE = 3'd4,
    K_UNTRACKED = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_RESP,
    S_RFIN,
    S_TICK,
    S_TFIN,
    S_EXP
  } state_t;

  typedef struct packed {
    logic [7:0] node;
    logic [7:0] proto;
    logic [15:0] cmd;
    logic [7:0] tag;
    logic [1:0] count;
    logic [TimeW-1:0] stamp;
  } entry_t;

  // control from sequencer to each cell
  typedef struct packed {
    logic shift;  // take the entry of the next cell up the row
    logic load;   // take the broadcast entry
  } cell_ctl_t;

  localparam logic [0:0] RegTimeout = 1'b0;
  localparam logic [0:0] RegMaxTx = 1'b1;
endpackage
`default_nettype wire

>>> rtl/orrt_cell.sv
`default_nettype none
module orrt_cell (
  input  wire logic                clk,
  input  wire orrt_pkg::cell_ctl_t ctl,
  input  wire orrt_pkg::entry_t    nbr,
  input  wire orrt_pkg::entry_t    ins,
  output orrt_pkg::entry_t         q
);
  import orrt_pkg::*;
  entry_t q_r;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r <= ins;
    end else if (ctl.shift) begin
      q_r <= nbr;
    end
  end
  assign q = q_r;
endmodule
`default_nettype wire

>>> rtl/outstanding_request_retry_tracker.sv
`default_nettype none
// Pending requests sit in a row of 16 cells, oldest at cell 0; only the
// cell 0 entry is inspected and the valid part of the row rotates through it.
// A request is taken when start is high and busy is low. Busy is high while
// a send reports its result. A response visits each of the n pending
// entries once, one per cycle, and then reports its last result. A tick pops
// the p timed-out front entries one per cycle, requeueing resends at the
// back, and then reports the x expired ones from a second row of cells. A
// match or a resend is held until the next one is found or the pass ends,
// so results come one per cycle at most, with gaps. Each result is valid
// for one cycle on out_strobe and the receiver cannot stall it.
module outstanding_request_retry_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_node_id,
  input  wire logic [7:0]  in_protocol_id,
  input  wire logic signed [15:0] in_command_code,
  input  wire logic [7:0]  in_request_tag,
  input  wire logic        in_wants_reply,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_strobe,
  output logic [2:0]       out_result_kind,
  output logic [7:0]       out_result_tag,
  output logic [7:0]       out_result_node,
  output logic [7:0]       out_result_protocol,
  output logic signed [15:0] out_result_command,
  output logic             out_last_result
);
  import orrt_pkg::*;

  state_t state_r, state_nxt;
  entry_t cell_q [Depth];
  entry_t xcell_q [Depth];
  cell_ctl_t ctl [Depth];
  cell_ctl_t xctl [Depth];
  entry_t ins;
  entry_t req_r, req_nxt;
  entry_t hold_r, hold_nxt;            // found result waiting for its last flag
  logic hold_v_r, hold_v_nxt;
  logic wants_r, wants_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;     // valid entries
  logic [CntW-1:0] step_r, step_nxt;   // entries left to visit
  logic [CntW-1:0] nexp_r, nexp_nxt;   // expired entries waiting
  logic [TimeW-1:0] time_r, time_nxt;
  logic [15:0] tmo_r;
  logic [1:0] mtx_r;
  logic row_adv, back_ld, ins_ld, exp_wr, exp_adv;
  kind_t okind;
  entry_t oent;
  logic ostb, olast;

  entry_t head;
  logic match, aged, resend;
  logic [15:0] lim;
  logic [TimeW-1:0] age;

  genvar g;
  generate
    for (g = 0; g < Depth; g++) begin : g_cell
      if (g == Depth - 1) begin : g_last
        orrt_cell u_cell (.clk(clk), .ctl(ctl[g]), .nbr(ins), .ins(ins), .q(cell_q[g]));
        orrt_cell u_xcell (.clk(clk), .ctl(xctl[g]), .nbr(head), .ins(head),
                           .q(xcell_q[g]));
      end else begin : g_mid
        orrt_cell u_cell (.clk(clk), .ctl(ctl[g]), .nbr(cell_q[g+1]), .ins(ins),
                          .q(cell_q[g]));
        orrt_cell u_xcell (.clk(clk), .ctl(xctl[g]), .nbr(xcell_q[g+1]), .ins(head),
                           .q(xcell_q[g]));
      end
    end
  endgenerate

  assign busy = (state_r != S_IDLE);
  assign head = cell_q[0];
  // compare as integers: a command of 32767 plus one never wraps to a match
  assign match = head.node == req_r.node && head.proto == req_r.proto &&
                 ({head.cmd[15], head.cmd} + 17'd1) == {req_r.cmd[15], req_r.cmd};
  assign lim = (tmo_r == 16'd0) ? 16'd1 : tmo_r;
  assign age = time_r - head.stamp;
  assign aged = age >= lim;
  assign resend = head.count < mtx_r;

  // row_adv moves the valid part of the row one cell down; back_ld refills
  // its last cell, ins_ld appends after it
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ctl[i].shift = row_adv && (CntW'(i + 1) < cnt_r);
      ctl[i].load = (back_ld && (CntW'(i + 1) == cnt_r)) ||
                    (ins_ld && (CntW'(i) == cnt_r));
      xctl[i].shift = exp_adv;
      xctl[i].load = exp_wr && (CntW'(i) == nexp_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        unique case (op_t'(in_operation))
          OP_SEND: state_nxt = S_SEND;
          OP_RESP: state_nxt = S_RESP;
          OP_TICK: state_nxt = S_TICK;
          OP_NONE: state_nxt = S_IDLE;
        endcase
      end
      S_SEND: state_nxt = S_IDLE;
      S_RESP: if (step_r == '0) state_nxt = S_RFIN;
      S_RFIN: state_nxt = S_IDLE;
      S_TICK: if (step_r == '0 || !aged) state_nxt = S_TFIN;
      S_TFIN: state_nxt = (nexp_r != '0) ? S_EXP : S_IDLE;
      S_EXP: if (nexp_r == CntW'(1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; step_nxt = step_r; nexp_nxt = nexp_r; time_nxt = time_r;
    req_nxt = req_r; wants_nxt = wants_r; hold_nxt = hold_r; hold_v_nxt = hold_v_r;
    row_adv = 1'b0; back_ld = 1'b0; ins_ld = 1'b0; exp_wr = 1'b0; exp_adv = 1'b0;
    ins = head; okind = K_XMIT; oent = hold_r; ostb = 1'b0; olast = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) begin
        req_nxt.node = in_node_id;
        req_nxt.proto = in_protocol_id;
        req_nxt.cmd = in_command_code;
        req_nxt.tag = in_request_tag;
        req_nxt.count = 2'd1;
        req_nxt.stamp = time_r;
        wants_nxt = in_wants_reply;
        step_nxt = cnt_r; nexp_nxt = '0; hold_v_nxt = 1'b0;
        if (op_t'(in_operation) == OP_TICK) time_nxt = time_r + TimeW'(1);
      end
      S_SEND: begin
        ostb = 1'b1; olast = 1'b1; oent = req_r; ins = req_r;
        if (wants_r) begin
          if (cnt_r == CntW'(Depth)) begin
            okind = K_UNTRACKED;
          end else begin
            ins_ld = 1'b1; cnt_nxt = cnt_r + CntW'(1);
          end
        end
      end
      S_RESP: if (step_r != '0) begin
        row_adv = 1'b1; step_nxt = step_r - CntW'(1);
        if (match) begin
          // drop the head; report the previous match, hold this one
          cnt_nxt = cnt_r - CntW'(1);
          hold_nxt = head; hold_v_nxt = 1'b1;
          ostb = hold_v_r; okind = K_MATCH;
        end else begin
          back_ld = 1'b1;
        end
      end
      S_RFIN: begin
        ostb = 1'b1; olast = 1'b1;
        if (hold_v_r) begin
          okind = K_MATCH;
        end else begin
          okind = K_UNASSIGN; oent = req_r; oent.tag = '0;
        end
      end
      S_TICK: if (step_r != '0 && aged) begin
        row_adv = 1'b1; step_nxt = step_r - CntW'(1);
        if (resend) begin
          back_ld = 1'b1;
          ins.count = head.count + 2'd1; ins.stamp = time_r;
          hold_nxt = head; hold_v_nxt = 1'b1;
          ostb = hold_v_r; okind = K_RESEND;
        end else begin
          exp_wr = 1'b1; nexp_nxt = nexp_r + CntW'(1); cnt_nxt = cnt_r - CntW'(1);
        end
      end
      S_TFIN: begin
        ostb = hold_v_r; okind = K_RESEND; olast = (nexp_r == '0);
      end
      S_EXP: begin
        ostb = 1'b1; okind = K_EXPIRE; oent = xcell_q[0];
        olast = (nexp_r == CntW'(1));
        exp_adv = 1'b1; nexp_nxt = nexp_r - CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      step_r <= '0;
      nexp_r <= '0;
      time_r <= '0;
      req_r <= '0;
      wants_r <= 1'b0;
      hold_r <= '0;
      hold_v_r <= 1'b0;
      tmo_r <= 16'd100;
      mtx_r <= 2'd3;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      step_r <= step_nxt;
      nexp_r <= nexp_nxt;
      time_r <= time_nxt;
      req_r <= req_nxt;
      wants_r <= wants_nxt;
      hold_r <= hold_nxt;
      hold_v_r <= hold_v_nxt;
      if (cfg_we) begin
        if (cfg_index == RegTimeout) begin
          tmo_r <= cfg_data;
        end else begin
          mtx_r <= cfg_data[1:0];
        end
      end
    end
  end

  assign out_strobe = ostb;
  assign out_result_kind = okind;
  assign out_result_tag = oent.tag;
  assign out_result_node = oent.node;
  assign out_result_protocol = oent.proto;
  assign out_result_command = oent.cmd;
  assign out_last_result = olast;
endmodule
`default_nettype wire
